### design/assert_macros.svh
// Assertion macros shared by the histogram quantile RTL.
// Included by the modules that carry concurrent checks; needs clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define HQM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define HQM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define HQM_ASSERT_IMP(lbl, ante, cons, msg)

`define HQM_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

### design/hqm_pkg.sv
// Shared constants for the histogram quantile block.
// No dependencies.
package hqm_pkg;

  localparam int PIXEL_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 23;

  localparam int PIXEL_IN_BITS  = 16;
  localparam int COUNTED_BITS   = 23;
  localparam int FRAC_BITS      = 17;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 17;

  localparam logic [FRAC_BITS-1:0] Q_ONE   = 17'h10000;
  localparam logic [FRAC_BITS-1:0] Q_RESET = 17'h08000;

  localparam logic [CFG_INDEX_BITS-1:0] REG_QUANTILE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_USE_MASK = 2'd1;

endpackage

### design/histogram_quantile_masked.sv
// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+---------------------------
// config    | cfg_write, cfg_index, cfg_data                | write when cfg_write high
// pixel in  | pixel_value, mask_on, frame_last              | taken when start & !busy
// result    | quantile_value, counted_pixels                | valid one cycle with done
//
// One pixel per cycle while busy is low; each bin update is a read-modify-write of
// the bin memory with one-deep forwarding. After the item with frame_last the block is
// busy through multiply, round, then a scan of every bin through the single read port
// (zeroing each bin behind it) and a drain state; done follows in the next cycle.
// After reset a clearing pass over every bin runs with busy high.
// Reset is synchronous; the result cannot be stalled.
// Uses hqm_pkg, assert_macros.svh, hqm_bin_ram and hqm_pixel_path.
`include "assert_macros.svh"

module histogram_quantile_masked
  import hqm_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      start,
  output logic                      busy,
  input  logic [PIXEL_IN_BITS-1:0]  pixel_value,
  input  logic                      mask_on,
  input  logic                      frame_last,
  output logic                      done,
  output logic [PIXEL_IN_BITS-1:0]  quantile_value,
  output logic [COUNTED_BITS-1:0]   counted_pixels
);

  localparam int PROD_BITS = COUNT_BITS + FRAC_BITS;
  localparam int CUM_BITS  = COUNT_BITS + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_RND   = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [FRAC_BITS-1:0]  frac;
  logic                  use_mask;
  logic                  accept;
  logic                  take;
  logic                  clearing;
  logic [PIXEL_BITS-1:0] scan_addr;
  logic                  sd_valid;
  logic [PIXEL_BITS-1:0] sd_addr;
  logic [PROD_BITS-1:0]  prod;
  logic [PROD_BITS-1:0]  prod_rnd;
  logic [CUM_BITS-1:0]   target;
  logic [CUM_BITS-1:0]   cum;
  logic [CUM_BITS-1:0]   cum_add;
  logic                  found;
  logic [PIXEL_BITS-1:0] found_val;
  logic                  hit;
  logic [PIXEL_BITS-1:0] final_val;

  logic [PIXEL_BITS-1:0] ram_rd_addr;
  logic [COUNT_BITS-1:0] ram_rd_data;
  logic                  ram_wr_en;
  logic [PIXEL_BITS-1:0] ram_wr_addr;
  logic [COUNT_BITS-1:0] ram_wr_data;
  logic [PIXEL_BITS-1:0] pix_rd_addr;
  logic                  pix_we;
  logic [PIXEL_BITS-1:0] pix_wr_addr;
  logic [COUNT_BITS-1:0] pix_wr_data;
  logic [COUNT_BITS-1:0] total;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign take     = accept && (!use_mask || mask_on);
  assign clearing = (state == ST_CLEAR) || (state == ST_SCAN);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frac     <= Q_RESET;
      use_mask <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_QUANTILE: frac <= (cfg_data > Q_ONE) ? Q_ONE : cfg_data;
        REG_USE_MASK: use_mask <= cfg_data[0];
        default: ;
      endcase
    end
  end

  hqm_pixel_path #(
    .PIXEL_BITS(PIXEL_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_pixel_path (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .pix        (pixel_value[PIXEL_BITS-1:0]),
    .clear_total(state == ST_DRAIN),
    .rd_data    (ram_rd_data),
    .rd_addr    (pix_rd_addr),
    .wr_en      (pix_we),
    .wr_addr    (pix_wr_addr),
    .wr_data    (pix_wr_data),
    .total      (total)
  );

  // the scan and the clearing pass zero each bin as they pass it
  assign ram_rd_addr = (state == ST_SCAN) ? scan_addr : pix_rd_addr;
  assign ram_wr_en   = pix_we || clearing;
  assign ram_wr_addr = clearing ? scan_addr : pix_wr_addr;
  assign ram_wr_data = clearing ? '0 : pix_wr_data;

  hqm_bin_ram #(
    .ADDR_BITS(PIXEL_BITS),
    .DATA_BITS(COUNT_BITS)
  ) u_bin_ram (
    .clk    (clk),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data)
  );

  always_comb begin
    prod_rnd  = prod + PROD_BITS'(32768);
    cum_add   = cum + CUM_BITS'(ram_rd_data);
    hit       = sd_valid && !found && (cum_add >= target);
    final_val = found ? found_val : (hit ? sd_addr : '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (scan_addr == '1) state_next = ST_IDLE;
      ST_IDLE:  if (accept && frame_last) state_next = ST_MUL;
      ST_MUL:   state_next = ST_RND;
      ST_RND:   state_next = ST_SCAN;
      ST_SCAN:  if (scan_addr == '1) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      scan_addr <= '0;
      sd_valid  <= 1'b0;
      found     <= 1'b0;
      done      <= 1'b0;
    end else begin
      state    <= state_next;
      sd_valid <= (state == ST_SCAN);
      done     <= (state == ST_DRAIN);
      if (clearing) begin
        scan_addr <= scan_addr + PIXEL_BITS'(1);
      end
      if (state == ST_RND) begin
        found <= 1'b0;
      end else if (hit) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod <= PROD_BITS'(total) * PROD_BITS'(frac);
    end
    if (state == ST_RND) begin
      target <= prod_rnd[PROD_BITS-1:16];
      cum    <= '0;
    end else if (sd_valid && !found) begin
      // frozen once found, so it never grows past twice the largest count
      cum <= cum_add;
    end
    if (hit) begin
      found_val <= sd_addr;
    end
    sd_addr <= scan_addr;
    if (state == ST_DRAIN) begin
      quantile_value <= PIXEL_IN_BITS'(final_val);
      counted_pixels <= COUNTED_BITS'(total);
    end
  end

  `HQM_ASSERT_IMP(a_no_write_clash, 1'b1, !(pix_we && clearing), "pixel write during bin sweep")
  `HQM_ASSERT_IMP(a_done_after_drain, done, $past(state) == ST_DRAIN, "result without scan")
  `HQM_ASSERT_NXT(a_done_single, done, !done, "result strobe held two cycles")
  `HQM_ASSERT_NXT(a_busy_after_last, accept && frame_last, busy, "last item did not start scan")

endmodule

### design/hqm_bin_ram.sv
// Bin count memory: one write port, one read port, registered read data.
// Uses hqm_pkg for default widths.
module hqm_bin_ram
  import hqm_pkg::*;
#(
  parameter int ADDR_BITS = PIXEL_BITS_DEF,
  parameter int DATA_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  // read-first: a read and a write to the same entry return the old count
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

### design/hqm_pixel_path.sv
// Pixel update path: read-modify-write of one bin per item, plus the running total.
// Uses hqm_pkg for default widths; drives the bin memory ports.
module hqm_pixel_path
  import hqm_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [PIXEL_BITS-1:0] pix,
  input  logic                  clear_total,
  input  logic [COUNT_BITS-1:0] rd_data,
  output logic [PIXEL_BITS-1:0] rd_addr,
  output logic                  wr_en,
  output logic [PIXEL_BITS-1:0] wr_addr,
  output logic [COUNT_BITS-1:0] wr_data,
  output logic [COUNT_BITS-1:0] total
);

  logic                  s1_valid;
  logic [PIXEL_BITS-1:0] s1_addr;
  logic                  fw_valid;
  logic [PIXEL_BITS-1:0] fw_addr;
  logic [COUNT_BITS-1:0] fw_data;
  logic [COUNT_BITS-1:0] cur;

  assign rd_addr = pix;

  // the write of the previous item lands in the same cycle as this item's read
  always_comb begin
    cur = (fw_valid && (fw_addr == s1_addr)) ? fw_data : rd_data;
    wr_data = (cur == '1) ? cur : cur + COUNT_BITS'(1);
  end

  assign wr_en   = s1_valid;
  assign wr_addr = s1_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fw_valid <= 1'b0;
      total    <= '0;
    end else begin
      s1_valid <= take;
      fw_valid <= s1_valid;
      if (clear_total) begin
        total <= '0;
      end else if (take && (total != '1)) begin
        total <= total + COUNT_BITS'(1);
      end
    end
    s1_addr <= pix;
    fw_addr <= s1_addr;
    fw_data <= wr_data;
  end

endmodule

### tb/hqm_quantile_checker.sv
`timescale 1ns / 1ps
// Checker for histogram_quantile_masked: follows the register writes, bins every
// accepted pixel item that the mask lets through and compares each frame's quantile
// result with its own prediction. Depends on hqm_pkg.
module hqm_quantile_checker
  import hqm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      start,
  input  logic                      busy,
  input  logic [PIXEL_IN_BITS-1:0]  pixel_value,
  input  logic                      mask_on,
  input  logic                      frame_last,
  input  logic                      done,
  input  logic [PIXEL_IN_BITS-1:0]  quantile_value,
  input  logic [COUNTED_BITS-1:0]   counted_pixels,
  output int                        mismatches,
  output int                        results_owed
);

  localparam int          NUM_BINS  = 1 << PIXEL_BITS_DEF;
  localparam int unsigned TALLY_MAX = 32'((64'd1 << COUNT_BITS_DEF) - 64'd1);

  typedef struct packed {
    logic [PIXEL_IN_BITS-1:0] quantile;
    logic [COUNTED_BITS-1:0]  counted;
  } frame_result_t;

  int unsigned          bin_tally [0:NUM_BINS-1];
  int unsigned          pixel_total;
  logic [FRAC_BITS-1:0] fraction;
  logic                 mask_enable;
  frame_result_t        frame_results_due [$];
  int                   error_count;

  function automatic int unsigned tally_up(int unsigned v);
    return (v < TALLY_MAX) ? v + 1 : v;
  endfunction

  function automatic void bin_pixel(logic [PIXEL_IN_BITS-1:0] pix, logic masked_in);
    int unsigned slot;
    slot = pix & (NUM_BINS - 1);
    if (!mask_enable || masked_in) begin
      bin_tally[slot] = tally_up(bin_tally[slot]);
      pixel_total     = tally_up(pixel_total);
    end
  endfunction

  // Rank is total * fraction rounded half up; the scan also empties the histogram.
  function automatic frame_result_t quantile_of_frame();
    frame_result_t     r;
    longint unsigned   rank;
    longint unsigned   running;
    bit                hit;
    rank = ((longint'(pixel_total) * longint'(fraction)) + 64'd32768) >> 16;
    running = 0;
    hit = 1'b0;
    r.quantile = '0;
    for (int v = 0; v < NUM_BINS; v++) begin
      running += bin_tally[v];
      if (!hit && running >= rank) begin
        hit = 1'b1;
        r.quantile = PIXEL_IN_BITS'(v);
      end
      bin_tally[v] = 0;
    end
    r.counted = pixel_total[COUNTED_BITS-1:0];
    pixel_total = 0;
    return r;
  endfunction

  function automatic void note_mismatch(string field, longint want, longint got);
    error_count++;
    if (error_count <= 10)
      $display("checker: %s expected %0d got %0d at %0t", field, want, got, $realtime);
  endfunction

  always @(posedge clk) begin : watch
    frame_result_t got;
    frame_result_t want;
    if (rst) begin
      foreach (bin_tally[i]) bin_tally[i] = 0;
      pixel_total = 0;
      fraction    = Q_RESET;
      mask_enable = 1'b0;
      frame_results_due.delete();
      error_count = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_QUANTILE) begin
          fraction = (cfg_data > Q_ONE) ? Q_ONE : cfg_data;
        end else if (cfg_index == REG_USE_MASK) begin
          mask_enable = cfg_data[0];
        end
      end
      if (done) begin
        got.quantile = quantile_value;
        got.counted  = counted_pixels;
        if (frame_results_due.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("checker: unexpected result %0d / %0d at %0t",
                     got.quantile, got.counted, $realtime);
        end else begin
          want = frame_results_due.pop_front();
          if (got.quantile != want.quantile)
            note_mismatch("quantile_value", want.quantile, got.quantile);
          if (got.counted != want.counted)
            note_mismatch("counted_pixels", want.counted, got.counted);
        end
      end
      if (start && !busy) begin
        bin_pixel(pixel_value, mask_on);
        if (frame_last) frame_results_due = {frame_results_due, quantile_of_frame()};
      end
    end
    mismatches   <= error_count;
    results_owed <= frame_results_due.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Top of the histogram_quantile_masked testbench: clock, reset, pixel and register
// stimulus, watchdog and verdict. Depends on hqm_pkg and hqm_quantile_checker.
module tb
  import hqm_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 300000;

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      cfg_write   = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index   = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data    = '0;
  logic                      start       = 1'b0;
  logic [PIXEL_IN_BITS-1:0]  pixel_value = '0;
  logic                      mask_on     = 1'b0;
  logic                      frame_last  = 1'b0;
  logic                      busy;
  logic                      done;
  logic [PIXEL_IN_BITS-1:0]  quantile_value;
  logic [COUNTED_BITS-1:0]   counted_pixels;

  int                        mismatches;
  int                        results_owed;
  int                        quiet_cycles = 0;
  bit                        gaps_on = 1'b1;
  int                        random_items = 0;
  int                        random_frames = 0;
  int                        frame_len;
  logic [PIXEL_IN_BITS-1:0]  pixel_pool [0:7];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  histogram_quantile_masked uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .pixel_value(pixel_value), .mask_on(mask_on), .frame_last(frame_last),
    .done(done), .quantile_value(quantile_value), .counted_pixels(counted_pixels)
  );

  hqm_quantile_checker quantile_watch (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .pixel_value(pixel_value), .mask_on(mask_on), .frame_last(frame_last),
    .done(done), .quantile_value(quantile_value), .counted_pixels(counted_pixels),
    .mismatches(mismatches), .results_owed(results_owed)
  );

  // a full bin scan sits well inside the limit; the clearing pass after reset too
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(logic [PIXEL_IN_BITS-1:0] pix, logic masked_in, logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start       <= 1'b0;
      pixel_value <= PIXEL_IN_BITS'($urandom);
      mask_on     <= 1'($urandom);
      frame_last  <= 1'($urandom);
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    start       <= 1'b1;
    pixel_value <= pix;
    mask_on     <= masked_in;
    frame_last  <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // results_owed is registered in the checker, hence the edge before the loop
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_registers(logic [CFG_DATA_BITS-1:0] frac, logic [CFG_DATA_BITS-1:0] mask_word);
    cfg_write <= 1'b1;
    cfg_index <= REG_QUANTILE;
    cfg_data  <= frac;
    @(posedge clk);
    cfg_index <= REG_USE_MASK;
    cfg_data  <= mask_word;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_fraction();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return Q_ONE;
      2:       return CFG_DATA_BITS'($urandom_range(32'h10001, 32'h1FFFF));
      3:       return Q_RESET;
      default: return CFG_DATA_BITS'($urandom_range(0, 32'h10000));
    endcase
  endfunction

  function automatic logic [PIXEL_IN_BITS-1:0] pick_pixel();
    case ($urandom_range(0, 3))
      0:       return pixel_pool[$urandom_range(0, 7)];
      1:       return PIXEL_IN_BITS'($urandom);
      2:       return PIXEL_IN_BITS'($urandom_range(0, 15));
      default: return PIXEL_IN_BITS'(16'hFFFF - $urandom_range(0, 15));
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // reset settings: median, mask off; five items so the rank rounds 2.5 up
    send_pixel(16'h0000, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 1'b1, 1'b0);
    send_pixel(16'hAAAA, 1'b0, 1'b0);
    send_pixel(16'h5555, 1'b1, 1'b0);
    send_pixel(16'h1234, 1'b0, 1'b1);
    drain();

    // full fraction with mask: top of the range wins
    set_registers(Q_ONE, 17'h00001);
    send_pixel(16'h0007, 1'b1, 1'b0);
    send_pixel(16'h0007, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 1'b1, 1'b0);
    send_pixel(16'h0003, 1'b1, 1'b1);
    // empty frame: everything masked out
    send_pixel(16'h0064, 1'b0, 1'b1);
    drain();

    // zero fraction on a non-empty frame
    set_registers(17'h00000, 17'h00000);
    send_pixel(16'd500, 1'b0, 1'b0);
    send_pixel(16'd40000, 1'b1, 1'b1);
    drain();

    // fraction above one is clamped; upper bits of the mask word ignored
    set_registers(17'h1FFFF, 17'h1FFFE);
    send_pixel(16'h0009, 1'b0, 1'b0);
    send_pixel(16'h0008, 1'b1, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b1);
    drain();

    set_registers(17'h07FFF, 17'h00001);
    send_pixel(16'h002A, 1'b1, 1'b0);
    send_pixel(16'hFFFE, 1'b1, 1'b0);
    send_pixel(16'h0003, 1'b0, 1'b1);

    // random frames, mostly short; settings change between some of them
    while (random_items < 730 || random_frames < 20) begin
      if ($urandom_range(0, 1) == 1) begin
        drain();
        set_registers(pick_fraction(), CFG_DATA_BITS'($urandom));
      end
      foreach (pixel_pool[i]) pixel_pool[i] = PIXEL_IN_BITS'($urandom);
      gaps_on   = (random_items < 650) && ($urandom_range(0, 3) != 0);
      frame_len = $urandom_range(1, 60);
      for (int n = 0; n < frame_len; n++) begin
        send_pixel(pick_pixel(), $urandom_range(0, 9) < 7, n == frame_len - 1);
        random_items++;
      end
      random_frames++;
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/hqm_pkg.sv
design/hqm_bin_ram.sv
design/hqm_pixel_path.sv
design/histogram_quantile_masked.sv
tb/hqm_quantile_checker.sv
tb/tb.sv
